@@ design/cbr_pkg.sv @@
package cbr_pkg;

	// masks for the swap network of a 16-bit reversal
	localparam logic [15:0] SWAP_MASK_1 = 16'h5555;
	localparam logic [15:0] SWAP_MASK_2 = 16'h3333;
	localparam logic [15:0] SWAP_MASK_4 = 16'h0f0f;
	localparam logic [15:0] SWAP_MASK_8 = 16'h00ff;

	localparam logic [3:0] POINTS_LOG2_RESET = 4'd10;
	localparam logic [4:0] POINTS_LOG2_MIN   = 5'd2;

	localparam logic OPC_SAMPLE = 1'b0;
	localparam logic OPC_DRAIN  = 1'b1;

	// per-cycle memory request from the sequencer
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic rd_last;
	} cbr_req_t;

	// reverse the low k bits of v (k in 1..16)
	function automatic logic [15:0] bitrev_k(logic [15:0] v, logic [4:0] k);
		logic [15:0] r;
		r = ((v & SWAP_MASK_1) << 1) | ((v >> 1) & SWAP_MASK_1);
		r = ((r & SWAP_MASK_2) << 2) | ((r >> 2) & SWAP_MASK_2);
		r = ((r & SWAP_MASK_4) << 4) | ((r >> 4) & SWAP_MASK_4);
		r = ((r & SWAP_MASK_8) << 8) | ((r >> 8) & SWAP_MASK_8);
		return r >> (5'd16 - k);
	endfunction

endpackage

@@ design/complex_bit_reverse_reorder.sv @@
// Path: a result passes the registered memory read and then the output queue
//   before it is offered on m_tvalid.
// Throughput: one transaction per cycle in and out while s_tready and m_tready
//   are high, set by the single write and read ports of the two-bank sample memory.
// Reset: arst_n clears counters, bank select, frame flag and queue; the sample
//   memory is not cleared, and no clearing pass is run.
module complex_bit_reverse_reorder #(
	parameter int MAX_LOG2_POINTS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] sample_re, [127:64] sample_im
	input  logic [0:0]   s_tuser,   // [0] opcode
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // [63:0] out_re, [127:64] out_im, [137:128] out_index
	output logic         m_tlast,   // frame_last
	// configuration: points_log2
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_data
);

	localparam int AW      = MAX_LOG2_POINTS;
	localparam int DEPTH   = 2 << MAX_LOG2_POINTS;  // two banks
	localparam int PAIR_W  = 128;
	localparam int ENTRY_W = PAIR_W + 11;           // pair, index, last

	cbr_pkg::cbr_req_t req;
	logic [AW:0]       wr_addr, rd_addr;
	logic [AW-1:0]     rd_index;
	logic              accept;

	// read in flight: memory data lands next cycle
	logic              valid_s1;
	logic [9:0]        index_s1;
	logic              last_s1;
	logic [PAIR_W-1:0] rdata;

	logic               fifo_valid, fifo_pop;
	logic [ENTRY_W-1:0] fifo_data;
	logic [2:0]         fifo_count;

	// Queue has four slots; accept only while queued plus in-flight results
	// leave room for two more. Full rate holds with one queued, one in flight.
	assign s_tready  = (fifo_count + 3'(valid_s1)) <= 3'd2;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	cbr_ctrl #(
		.MAX_LOG2_POINTS(MAX_LOG2_POINTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.accept   (accept),
		.opcode   (s_tuser[0]),
		.req      (req),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.rd_index (rd_index)
	);

	// Fill bank and read bank always differ, since the read side uses the inverted
	// bank select; a freshly swapped bank is read no earlier than the cycle after its last write.
	cbr_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (wr_addr),
		.wdata (s_tdata),
		.re    (req.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			index_s1 <= 10'(rd_index);
			last_s1  <= req.rd_last;
		end
	end

	assign fifo_pop = fifo_valid && m_tready;

	cbr_out_fifo #(
		.WIDTH(ENTRY_W)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data ({last_s1, index_s1, rdata}),
		.pop       (fifo_pop),
		.valid     (fifo_valid),
		.data      (fifo_data),
		.count     (fifo_count)
	);

	assign m_tvalid = fifo_valid;
	assign m_tdata  = {6'd0, fifo_data[ENTRY_W-2:0]};
	assign m_tlast  = fifo_data[ENTRY_W-1];

	// queue never overflows
	assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count + 3'(valid_s1)) <= 3'd3)
		else $error("output queue overflow");

	// a read and a write in one cycle never touch the same bank
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.wr_en && req.rd_en) |-> (wr_addr[AW] != rd_addr[AW]))
		else $error("read and write hit the same bank");

	// a read in flight comes only from an accepted transaction with a full frame
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(accept && req.rd_en))
		else $error("read in flight without a source transaction");

endmodule

@@ design/cbr_ram.sv @@
module cbr_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/cbr_ctrl.sv @@
module cbr_ctrl #(
	parameter int MAX_LOG2_POINTS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [3:0]                   cfg_data,
	input  logic                         accept,
	input  logic                         opcode,
	output cbr_pkg::cbr_req_t            req,
	output logic [MAX_LOG2_POINTS:0]     wr_addr,
	output logic [MAX_LOG2_POINTS:0]     rd_addr,
	output logic [MAX_LOG2_POINTS-1:0]   rd_index
);

	localparam int AW = MAX_LOG2_POINTS;
	localparam logic [4:0] LOG2_MAX = 5'(MAX_LOG2_POINTS);

	logic [3:0]    points_log2_q;
	logic [AW-1:0] fill_count_q, drain_count_q;
	logic          fill_bank_q, frame_ready_q;

	logic [4:0]    k_eff;
	logic [AW-1:0] last_pos;
	logic [15:0]   fill_rev;
	logic          is_sample;
	logic          fill_done, drain_done;

	always_comb begin
		k_eff = {1'b0, points_log2_q};
		if (k_eff < cbr_pkg::POINTS_LOG2_MIN) begin
			k_eff = cbr_pkg::POINTS_LOG2_MIN;
		end else if (k_eff > LOG2_MAX) begin
			k_eff = LOG2_MAX;
		end
	end

	assign last_pos   = {AW{1'b1}} >> (LOG2_MAX - k_eff);
	assign fill_rev   = cbr_pkg::bitrev_k(16'(fill_count_q), k_eff);
	assign is_sample  = (opcode == cbr_pkg::OPC_SAMPLE);
	assign fill_done  = (fill_count_q == last_pos);
	assign drain_done = (drain_count_q == last_pos);

	assign req.wr_en   = accept && is_sample;
	assign req.rd_en   = accept && frame_ready_q;
	assign req.rd_last = drain_done;
	assign wr_addr     = {fill_bank_q, fill_rev[AW-1:0]};
	assign rd_addr     = {~fill_bank_q, drain_count_q};
	assign rd_index    = drain_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_log2_q <= cbr_pkg::POINTS_LOG2_RESET;
			fill_count_q  <= '0;
			drain_count_q <= '0;
			fill_bank_q   <= 1'b0;
			frame_ready_q <= 1'b0;
		end else if (cfg_we) begin
			// new length abandons partial and pending frames
			points_log2_q <= cfg_data;
			fill_count_q  <= '0;
			drain_count_q <= '0;
			frame_ready_q <= 1'b0;
		end else if (accept) begin
			if (frame_ready_q) begin
				if (drain_done) begin
					drain_count_q <= '0;
					frame_ready_q <= 1'b0;
				end else begin
					drain_count_q <= drain_count_q + 1'b1;
				end
			end
			if (is_sample) begin
				if (fill_done) begin
					fill_count_q  <= '0;
					fill_bank_q   <= ~fill_bank_q;
					drain_count_q <= '0;
					frame_ready_q <= 1'b1;
				end else begin
					fill_count_q <= fill_count_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ design/cbr_out_fifo.sv @@
module cbr_out_fifo #(
	parameter int WIDTH = 139
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] data,
	output logic [2:0]       count
);

	logic [WIDTH-1:0] slot_q [4];
	logic [1:0]       wr_ptr_q, rd_ptr_q;
	logic [2:0]       count_q;

	assign valid = (count_q != 3'd0);
	assign data  = slot_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

endmodule
